>>> design/bds_pkg.sv
// Shared constants and types for the baud divisor search.
// No dependencies; used by bds_divider and baud_divider_search.
`default_nettype none

package bds_pkg;

    localparam int DIVD_W = 42;   // dividend / quotient width of the serial divider
    localparam int DIVS_W = 41;   // divisor width of the serial divider
    localparam int STEP_W = 6;    // step counter, holds DIVD_W

    localparam logic [15:0] FALLBACK_COUNT   = 16'h028B;
    localparam logic [7:0]  FALLBACK_DIVIDER = 8'd15;
    localparam logic [7:0]  DIVIDER_FIRST    = 8'd4;
    localparam logic [7:0]  DIVIDER_LAST     = 8'd255;
    localparam logic [31:0] ERROR_START      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_resp;

endpackage

`default_nettype wire

>>> design/bds_divider.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on bds_pkg for widths and the request/response structs.
`default_nettype none

module bds_divider (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  bds_pkg::t_div_req    i_req,
    output bds_pkg::t_div_resp   o_resp
);
    import bds_pkg::*;

    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIVD_W-1:0] rem_sh;
    logic [DIVD_W:0]   trial;
    logic              q_bit;

    // remainder stays below the divisor, so the shifted value fits
    assign rem_sh = {r_rem[DIVD_W-2:0], r_quo[DIVD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign q_bit  = ~trial[DIVD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= q_bit ? trial[DIVD_W-1:0] : rem_sh;
            r_quo <= {r_quo[DIVD_W-2:0], q_bit};
        end
    end

    assign o_resp.done     = r_done;
    assign o_resp.quotient = r_quo;

endmodule

`default_nettype wire

>>> design/baud_divider_search.sv
// Top level of the baud divisor search: sequencer, best-pair tracking, stream ports.
// Depends on bds_pkg and bds_divider.
//
// Usage: one word on the slave stream carries clock_hz and target_baud. The block
// walks every divider setting from 4 to 255; for each it forms the rounded count,
// then the actual rate, both through one shared 42-step serial divider, and keeps
// the pair with the strictly smallest rate error. One word on the master stream
// returns rate_count and divider_setting.
// Each divider whose count fits takes two divisions, each started from its own state and
// collected in a wait state, plus multiply and compare states; a divider with an
// oversized count is skipped after its first division. A full sweep covers 252
// dividers, and an exact match stops the sweep early.
// A zero target_baud skips the sweep; S_DONE loads the fallback pair for output.
// Throughput: one search at a time; s_axis_tready is high only while idle.
// The result sits in an output register: a stalled receiver holds m_axis_tvalid
// and the data steady, and the next word may be taken meanwhile; a second result
// waits in the sequencer until the register is free.
// Reset (synchronous, active low) abandons any search and drops m_axis_tvalid.
`default_nettype none

module baud_divider_search (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [31:0] clock_hz, [63:32] target_baud
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata    // [15:0] rate_count, [23:16] divider_setting
);
    import bds_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_WAIT1 = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_DIV2  = 4'd5;
    localparam logic [3:0] S_WAIT2 = 4'd6;
    localparam logic [3:0] S_EVAL  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]        r_state;
    logic [31:0]       r_clk_hz;
    logic [31:0]       r_baud;
    logic [7:0]        r_div;
    logic [40:0]       r_denom;
    logic [15:0]       r_count;
    logic [24:0]       r_prod;
    logic [31:0]       r_actual;
    logic [31:0]       r_least_err;
    logic [15:0]       r_best_count;
    logic [7:0]        r_best_div;
    logic              r_out_valid;
    logic [23:0]       r_out_data;

    t_div_req          div_req;
    t_div_resp         div_resp;

    logic [8:0]        span;
    logic [DIVD_W-1:0] num;
    logic [DIVD_W-1:0] cnt_clamped;
    logic [31:0]       err;
    logic              out_free;

    bds_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_resp  (div_resp)
    );

    assign span = {1'b0, r_div} + 9'd1;
    // rounded quotient: add half the divisor to the clock
    assign num  = {10'd0, r_clk_hz} + {2'b00, r_denom[40:1]};
    assign cnt_clamped = (div_resp.quotient == '0) ? DIVD_W'(1) : div_resp.quotient;
    assign err  = (r_actual > r_baud) ? (r_actual - r_baud) : (r_baud - r_actual);
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = num;
        div_req.divisor  = r_denom;
        case (r_state)
            S_DIV1: begin
                div_req.start = 1'b1;
            end
            S_DIV2: begin
                div_req.start    = 1'b1;
                div_req.dividend = {10'd0, r_clk_hz};
                div_req.divisor  = {16'd0, r_prod};
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_clk_hz     <= s_axis_tdata[31:0];
                        r_baud       <= s_axis_tdata[63:32];
                        r_div        <= DIVIDER_FIRST;
                        r_least_err  <= ERROR_START;
                        r_best_count <= FALLBACK_COUNT;
                        r_best_div   <= FALLBACK_DIVIDER;
                        r_state      <= (s_axis_tdata[63:32] == 32'd0) ? S_DONE : S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_denom <= {9'd0, r_baud} * {32'd0, span};
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    r_state <= S_WAIT1;
                end
                S_WAIT1: begin
                    if (div_resp.done) begin
                        if (|cnt_clamped[DIVD_W-1:16]) begin
                            // count too large for the generator: skip this divider
                            if (r_div == DIVIDER_LAST) begin
                                r_state <= S_DONE;
                            end else begin
                                r_div   <= r_div + 8'd1;
                                r_state <= S_MUL1;
                            end
                        end else begin
                            r_count <= cnt_clamped[15:0];
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_prod  <= {16'd0, span} * {9'd0, r_count};
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    r_state <= S_WAIT2;
                end
                S_WAIT2: begin
                    if (div_resp.done) begin
                        r_actual <= div_resp.quotient[31:0];
                        r_state  <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (err < r_least_err) begin
                        r_least_err  <= err;
                        r_best_count <= r_count;
                        r_best_div   <= r_div;
                    end
                    if ((err < r_least_err && err == 32'd0) || r_div == DIVIDER_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_div   <= r_div + 8'd1;
                        r_state <= S_MUL1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_data  <= {r_best_div, r_best_count};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> test/baud_divider_search_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for baud_divider_search: directed and random clock/baud words,
// with a scoreboard class that predicts the best divisor pair. Depends on bds_pkg.

module baud_divider_search_test;
    import bds_pkg::*;

    localparam logic [63:0] COUNT_LIMIT   = 64'd65535;
    localparam int          STALL_LIMIT   = 100000;
    localparam int          LONG_HOLD     = 3000;
    localparam int          SETTLE_CYCLES = 200;
    localparam int          RANDOM_WORDS  = 78;
    localparam int          NO_GAP_WORDS  = 15;
    localparam int          MAX_REPORTS   = 10;

    typedef struct packed {
        logic [15:0] count;
        logic [7:0]  divider;
    } divisor_pair_t;

    class divisor_scoreboard;
        divisor_pair_t expected_pairs[$];
        int            mismatches;

        function divisor_pair_t best_divisors(logic [31:0] clock_hz, logic [31:0] target_baud);
            logic [63:0]   span;
            logic [63:0]   denom;
            logic [63:0]   count;
            logic [63:0]   actual;
            logic [31:0]   err;
            logic [31:0]   least_err;
            logic          exact;
            divisor_pair_t best;
            least_err    = ERROR_START;
            best.count   = FALLBACK_COUNT;
            best.divider = FALLBACK_DIVIDER;
            exact        = 1'b0;
            if (target_baud != 32'd0) begin
                for (int unsigned d = DIVIDER_FIRST; d <= DIVIDER_LAST && !exact; d++) begin
                    span  = 64'(d) + 64'd1;
                    denom = {32'd0, target_baud} * span;
                    count = ({32'd0, clock_hz} + (denom >> 1)) / denom;
                    if (count == 64'd0)
                        count = 64'd1;
                    if (count <= COUNT_LIMIT) begin
                        actual = {32'd0, clock_hz} / (span * count);
                        err = (actual[31:0] > target_baud) ? actual[31:0] - target_baud
                                                           : target_baud - actual[31:0];
                        // only a strictly better error wins, so ties keep the lower divider
                        if (err < least_err) begin
                            least_err    = err;
                            best.count   = count[15:0];
                            best.divider = 8'(d);
                            exact        = (err == 32'd0);
                        end
                    end
                end
            end
            return best;
        endfunction

        function void note_input(logic [31:0] clock_hz, logic [31:0] target_baud);
            expected_pairs.push_back(best_divisors(clock_hz, target_baud));
        endfunction

        function void check_result(logic [15:0] count, logic [7:0] divider);
            divisor_pair_t want;
            if (expected_pairs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word, count %0d divider %0d",
                             $time, count, divider);
            end else begin
                want = expected_pairs.pop_front();
                if (count !== want.count || divider !== want.divider) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: got count %0d divider %0d, expected count %0d divider %0d",
                                 $time, count, divider, want.count, want.divider);
                end
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;     // [31:0] clock_hz, [63:32] target_baud
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [15:0] rate_count, [23:16] divider_setting

    bit no_gaps      = 1'b0;
    bit hold_request = 1'b0;
    int idle_cycles  = 0;

    divisor_scoreboard sb = new();

    baud_divider_search i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // tvalid is left high after a word so back-to-back words never toggle it in one step
    task automatic send_word(input logic [31:0] clock_hz, input logic [31:0] target_baud);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {target_baud, clock_hz};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(clock_hz, target_baud);
        @(negedge i_clk);
    endtask

    // clock built so that the given divider and count hit the baud rate exactly
    task automatic send_exact(input int unsigned divider, input int unsigned count);
        logic [63:0] step;
        logic [63:0] room;
        logic [63:0] baud;
        step = (64'(divider) + 64'd1) * 64'(count);
        room = 64'hFFFF_FFFF / step;
        baud = 64'($urandom_range(1, 32'(room))) >> $urandom_range(0, 24);
        if (baud == 64'd0)
            baud = 64'd1;
        send_word(32'(baud * step), 32'(baud));
    endtask

    task automatic send_random();
        int unsigned pick;
        int unsigned divider;
        int unsigned count;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_word($urandom(), 32'd0);
        end else if (pick < 18) begin
            // free pairs mostly sweep all dividers, so keep them few
            send_word($urandom(), $urandom() >> $urandom_range(0, 31));
        end else begin
            divider = (pick < 25) ? $urandom_range(DIVIDER_FIRST, DIVIDER_LAST)
                                  : $urandom_range(DIVIDER_FIRST, 12);
            count   = 1 + ($urandom_range(0, 65534) >> $urandom_range(0, 15));
            send_exact(divider, count);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata[15:0], m_axis_tdata[23:16]);
            @(negedge i_clk);
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(32'd0, 32'd0);                        // zero target, fallback
        send_word(32'hFFFF_FFFF, 32'd0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'd0, 32'hFFFF_FFFF);                // every error is all ones: fallback
        send_word(32'd0, 32'd1);                        // count clamped to 1, ties everywhere
        send_word(32'hFFFF_FFFF, 32'd1);                // every count too large: fallback
        send_word(32'd5, 32'd1);                        // exact on the first divider
        send_word(32'd16776960, 32'd1);                 // exact on the last divider, top count
        send_word(32'd8, 32'd1);                        // count rounds up, then exact at 5
        send_word(32'd1843200, 32'd115200);
        send_word(32'd50000000, 32'd115200);
        send_word(32'd100000000, 32'd9600);
        send_word(32'd100, 32'd1000);                   // target above the clock
        send_word(32'h8000_0000, 32'd1);
        send_word(32'h7FFF_FFFF, 32'h0001_0000);
        send_word(32'hAAAA_AAAA, 32'h5555_5555);

        no_gaps = 1'b1;
        repeat (NO_GAP_WORDS) send_random();
        no_gaps = 1'b0;

        // receiver holds off while fast words back up through the block
        drain();
        hold_request = 1'b1;
        repeat (3) begin
            send_word($urandom(), 32'd0);
            send_exact(DIVIDER_FIRST, 1);
        end
        drain();

        repeat (RANDOM_WORDS - NO_GAP_WORDS) send_random();
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> baud_divider_search.f
design/bds_pkg.sv
design/bds_divider.sv
design/baud_divider_search.sv
test/baud_divider_search_test.sv
